FILE: src/gwm_pkg.sv
// Package for the glob wildcard matcher: pattern sizes, special characters,
// register indexes and the star-closure and case-fold helpers.
// No dependencies.
package gwm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int NUM_POS     = MAX_PATTERN + 1;
   localparam int LEN_W       = 6;
   localparam int WORD_W      = 64;
   localparam int CHAR_W      = 8;
   localparam int CHARS_PER_WORD = WORD_W / CHAR_W;
   localparam int NUM_WORDS   = 4;

   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   typedef logic [NUM_POS-1:0] pos_vec_type;

   typedef enum logic [2:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4,
      CSR_CASE_FOLD      = 3'd5,
      CSR_PATTERN_ENABLE = 3'd6
   } csr_index_type;

   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   // Star closure as a carry chain: a set bit under a star carries into the
   // next position and keeps carrying through a run of stars.
   function automatic pos_vec_type close_stars(input pos_vec_type s,
                                               input pos_vec_type star);
      pos_vec_type gen;
      logic [NUM_POS:0] sum;
      pos_vec_type carry;
      gen   = s & star;
      sum   = {1'b0, gen} + {1'b0, star};
      carry = sum[NUM_POS-1:0] ^ gen ^ star;
      return s | carry;
   endfunction

endpackage

FILE: src/glob_wildcard_matcher_core.sv
// Glob wildcard matcher top level: bit-parallel NFA over the pattern
// positions, one character per transfer. Depends on gwm_pkg.
//
// channel  direction  ports                                   transfer when
// req      in         req_text_char, req_last                 req_valid & req_ready
// rsp      out        rsp_match_here, rsp_last_res            rsp_valid & rsp_ready
// csr      in         csr_index, csr_wdata                    csr_write_en
//
// One character per cycle while req_ready is high; each result is registered in
// the cycle after its transfer, set by the NFA step and star closure between the
// closed-state register and the result register. A csr write holds req_ready low
// for the following cycle while the closed state is rebuilt for the new pattern.
// Reset is synchronous; the result register holds while rsp_ready is low.
module glob_wildcard_matcher_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gwm_pkg::CHAR_W-1:0]        req_text_char,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_match_here,
   output logic                              rsp_last_res,
   input  logic                              csr_write_en,
   input  logic [2:0]                        csr_index,
   input  logic [gwm_pkg::WORD_W-1:0]        csr_wdata
);
   import gwm_pkg::*;

   logic [WORD_W-1:0] pattern_word_ff [NUM_WORDS];
   logic [LEN_W-1:0]  pattern_length_ff;
   logic              case_fold_ff;
   logic              pattern_enable_ff;
   logic              dirty_ff;
   pos_vec_type       alive_ff;
   pos_vec_type       alive_in;
   pos_vec_type       cur_ff;
   pos_vec_type       cur_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              match_ff;
   logic              match_in;
   logic              last_ff;

   logic [LEN_W-1:0]  eff_len;
   logic [CHAR_W-1:0] pat_char [MAX_PATTERN];
   pos_vec_type       live_mask;
   pos_vec_type       star_vec;
   pos_vec_type       adv_vec;
   pos_vec_type       nxt;
   pos_vec_type       nxt_closed;
   pos_vec_type       close_src;
   logic [CHAR_W-1:0] text_cmp;
   logic              req_xfer;
   logic              rsp_xfer;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign req_ready = !dirty_ff && (!rsp_valid_ff || rsp_ready);

   assign eff_len = (pattern_length_ff > LEN_W'(MAX_PATTERN)) ?
                    LEN_W'(MAX_PATTERN) : pattern_length_ff;

   assign text_cmp = case_fold_ff ? fold_char(req_text_char) : req_text_char;

   always_comb begin
      live_mask = '0;
      star_vec  = '0;
      adv_vec   = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_char[i] = pattern_word_ff[i / CHARS_PER_WORD]
                       [(i % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
         live_mask[i] = (LEN_W'(i) <= eff_len);
         if (LEN_W'(i) < eff_len) begin
            star_vec[i] = (pat_char[i] == CHAR_STAR);
            if (pat_char[i] == CHAR_QMARK) begin
               adv_vec[i] = 1'b1;
            end else if (pat_char[i] != CHAR_STAR) begin
               adv_vec[i] = case_fold_ff ? (fold_char(pat_char[i]) == text_cmp)
                                         : (pat_char[i] == text_cmp);
            end
         end
      end
      live_mask[MAX_PATTERN] = (eff_len == LEN_W'(MAX_PATTERN));
   end

   // advance one character from the closed state
   assign nxt        = (cur_ff & star_vec) | ((cur_ff & adv_vec) << 1);
   assign nxt_closed = close_stars(nxt, star_vec);
   assign match_in   = pattern_enable_ff ? nxt_closed[eff_len] : 1'b1;

   always_comb begin
      if (dirty_ff) begin
         close_src = alive_ff & live_mask;
      end else if (req_last) begin
         close_src = NUM_POS'(1);
      end else begin
         close_src = nxt;
      end
   end

   assign cur_in       = close_stars(close_src, star_vec);
   assign alive_in     = req_last ? NUM_POS'(1) : nxt;
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            pattern_word_ff[w] <= '0;
         end
         pattern_length_ff <= '0;
         case_fold_ff      <= 1'b0;
         pattern_enable_ff <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PATTERN_WORD_0: pattern_word_ff[0] <= csr_wdata;
            CSR_PATTERN_WORD_1: pattern_word_ff[1] <= csr_wdata;
            CSR_PATTERN_WORD_2: pattern_word_ff[2] <= csr_wdata;
            CSR_PATTERN_WORD_3: pattern_word_ff[3] <= csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_CASE_FOLD:      case_fold_ff      <= csr_wdata[0];
            CSR_PATTERN_ENABLE: pattern_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff     <= 1'b0;
         alive_ff     <= NUM_POS'(1);
         cur_ff       <= NUM_POS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         dirty_ff     <= csr_write_en;
         rsp_valid_ff <= rsp_valid_in;
         if (dirty_ff || req_xfer) begin
            cur_ff <= cur_in;
         end
         if (req_xfer) begin
            alive_ff <= alive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         match_ff <= match_in;
         last_ff  <= req_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match_here = match_ff;
   assign rsp_last_res   = last_ff;

endmodule

FILE: src/gwm_checker.sv
// Port-level checker for the glob wildcard matcher, bound to the top level.
// Depends on gwm_pkg and glob_wildcard_matcher_core.
module gwm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_match_here,
   input logic                        rsp_last_res,
   input logic                        csr_write_en
);
   import gwm_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_here)
                                  && $stable(rsp_last_res))
      else $error("stalled result changed");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result without transfer");

   a_csr_hold: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !req_ready)
      else $error("input taken while pattern state rebuilds");

endmodule

bind glob_wildcard_matcher_core gwm_checker u_gwm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_match_here (rsp_match_here),
   .rsp_last_res   (rsp_last_res),
   .csr_write_en   (csr_write_en)
);

FILE: test/glob_wildcard_matcher_core_tb.sv
// Self-checking testbench for glob_wildcard_matcher_core: streams names against
// wildcard patterns and checks every per-character verdict against a local NFA.
// Depends on gwm_pkg and the glob_wildcard_matcher_core RTL.
module glob_wildcard_matcher_core_tb;
   import gwm_pkg::*;

   localparam int RANDOM_CHARS = 1100;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct packed {
      logic match_here;
      logic last_res;
   } verdict_type;

   class match_scoreboard;
      logic [WORD_W-1:0] pat_word [NUM_WORDS];
      logic [LEN_W-1:0]  pat_len;
      logic              fold_on;
      logic              enabled;
      pos_vec_type       alive;
      verdict_type       verdicts [$];
      int                errors;
      int                checked;
      int                name_hits;

      function new();
         foreach (pat_word[i]) begin
            pat_word[i] = '0;
         end
         pat_len   = '0;
         fold_on   = 1'b0;
         enabled   = 1'b1;
         alive     = pos_vec_type'(1);
         errors    = 0;
         checked   = 0;
         name_hits = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_PATTERN_WORD_0: begin
               pat_word[0] = data;
            end
            CSR_PATTERN_WORD_1: begin
               pat_word[1] = data;
            end
            CSR_PATTERN_WORD_2: begin
               pat_word[2] = data;
            end
            CSR_PATTERN_WORD_3: begin
               pat_word[3] = data;
            end
            CSR_PATTERN_LENGTH: begin
               pat_len = data[LEN_W-1:0];
            end
            CSR_CASE_FOLD: begin
               fold_on = data[0];
            end
            CSR_PATTERN_ENABLE: begin
               enabled = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [CHAR_W-1:0] pat_char(int unsigned i);
         return pat_word[i / CHARS_PER_WORD][CHAR_W * (i % CHARS_PER_WORD) +: CHAR_W];
      endfunction

      function logic [CHAR_W-1:0] lower(logic [CHAR_W-1:0] c);
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
         end
         return c;
      endfunction

      // a live star also makes the next position live, through runs of stars
      function pos_vec_type spread_stars(pos_vec_type s, int unsigned n);
         int unsigned i;
         for (i = 0; i < n; i++) begin
            if (s[i] && pat_char(i) == CHAR_STAR) begin
               s[i+1] = 1'b1;
            end
         end
         return s;
      endfunction

      function void note_char(logic [CHAR_W-1:0] c, logic l);
         int unsigned n;
         int unsigned i;
         pos_vec_type live;
         pos_vec_type cur;
         pos_vec_type nxt;
         pos_vec_type reach;
         logic [CHAR_W-1:0] p;
         logic [CHAR_W-1:0] a;
         logic [CHAR_W-1:0] b;
         verdict_type v;
         n = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
         live = '0;
         for (i = 0; i <= n; i++) begin
            live[i] = 1'b1;
         end
         cur = spread_stars(alive & live, n);
         nxt = '0;
         for (i = 0; i < n; i++) begin
            if (cur[i]) begin
               p = pat_char(i);
               if (p == CHAR_STAR) begin
                  nxt[i] = 1'b1;
               end else if (p == CHAR_QMARK) begin
                  nxt[i+1] = 1'b1;
               end else begin
                  a = fold_on ? lower(p) : p;
                  b = fold_on ? lower(c) : c;
                  if (a == b) begin
                     nxt[i+1] = 1'b1;
                  end
               end
            end
         end
         reach = spread_stars(nxt, n);
         v.match_here = enabled ? reach[n] : 1'b1;
         v.last_res   = l;
         alive = l ? pos_vec_type'(1) : nxt;
         verdicts.push_back(v);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_result(logic m, logic l);
         verdict_type want;
         if (verdicts.size() == 0) begin
            report($sformatf("unexpected result match_here=%0b last_res=%0b", m, l));
            return;
         end
         want = verdicts.pop_front();
         checked++;
         if (m !== want.match_here) begin
            report($sformatf("result %0d match_here=%0b, want %0b", checked, m,
                             want.match_here));
         end
         if (l !== want.last_res) begin
            report($sformatf("result %0d last_res=%0b, want %0b", checked, l,
                             want.last_res));
         end
         if (l === 1'b1 && m === 1'b1) begin
            name_hits++;
         end
      endtask

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_text_char = '0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_match_here;
   logic                rsp_last_res;
   logic                csr_write_en = 1'b0;
   logic [2:0]          csr_index = '0;
   logic [WORD_W-1:0]   csr_wdata = '0;

   match_scoreboard     sb;
   logic                calm = 1'b0;
   int                  chars_sent = 0;
   int                  names_sent = 0;
   int                  settings_used = 0;
   int                  cycle_count = 0;
   logic [CHAR_W-1:0]   phase_pat [MAX_PATTERN];
   logic [CHAR_W-1:0]   name_q [$];

   glob_wildcard_matcher_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_char  (req_text_char),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_match_here (rsp_match_here),
      .rsp_last_res   (rsp_last_res),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic write_csr(csr_index_type idx, logic [WORD_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_regs(logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                           logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3,
                           int len, logic fold, logic en);
      write_csr(CSR_PATTERN_WORD_0, w0);
      write_csr(CSR_PATTERN_WORD_1, w1);
      write_csr(CSR_PATTERN_WORD_2, w2);
      write_csr(CSR_PATTERN_WORD_3, w3);
      write_csr(CSR_PATTERN_LENGTH, WORD_W'(len));
      write_csr(CSR_CASE_FOLD, WORD_W'(fold));
      write_csr(CSR_PATTERN_ENABLE, WORD_W'(en));
      settings_used++;
   endtask

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_char(logic [CHAR_W-1:0] c, logic l);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_text_char = c;
      req_last      = l;
      req_valid     = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_char(c, l);
      chars_sent++;
      if (l) begin
         names_sent++;
      end
      @(negedge clock);
   endtask

   task automatic send_text(string s, logic close);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_char(s[i], close && (i == s.len() - 1));
      end
   endtask

   // drop valid and hold until every verdict has come back
   task automatic settle();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] text_char();
      string pool;
      pool = "abcABCzZ.-*?";
      if ($urandom_range(0, 3) == 0) begin
         return CHAR_W'($urandom_range(0, 255));
      end
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   function automatic logic [CHAR_W-1:0] pattern_char();
      string pool;
      int r;
      pool = "abcABC.z";
      r = $urandom_range(0, 31);
      if (r < 6) begin
         return CHAR_STAR;
      end else if (r < 10) begin
         return CHAR_QMARK;
      end else if (r < 26) begin
         return pool[$urandom_range(0, pool.len() - 1)];
      end else if (r == 26) begin
         return '0;
      end
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CHAR_W-1:0] swap_case(logic [CHAR_W-1:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end else if (c >= "a" && c <= "z") begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [WORD_W-1:0] pack_word(int k);
      logic [WORD_W-1:0] w;
      int j;
      for (j = 0; j < CHARS_PER_WORD; j++) begin
         w[CHAR_W*j +: CHAR_W] = phase_pat[CHARS_PER_WORD*k + j];
      end
      return w;
   endfunction

   // mostly names that follow the pattern, some mutated, some pure noise
   task automatic build_name(int n, logic fold);
      int i;
      int pos;
      logic [CHAR_W-1:0] p;
      name_q.delete();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 6)) name_q.push_back(CHAR_W'($urandom_range(0, 255)));
         return;
      end
      for (i = 0; i < n; i++) begin
         p = phase_pat[i];
         if (p == CHAR_STAR) begin
            repeat ($urandom_range(0, 3)) name_q.push_back(text_char());
         end else if (p == CHAR_QMARK) begin
            name_q.push_back(CHAR_W'($urandom_range(0, 255)));
         end else if (fold && $urandom_range(0, 1) == 1) begin
            name_q.push_back(swap_case(p));
         end else begin
            name_q.push_back(p);
         end
      end
      if (name_q.size() > 0 && $urandom_range(0, 3) == 0) begin
         pos = $urandom_range(0, name_q.size() - 1);
         case ($urandom_range(0, 2))
            0: begin
               name_q[pos] = text_char();
            end
            1: begin
               name_q.delete(pos);
            end
            default: begin
               name_q.insert(pos, text_char());
            end
         endcase
      end
      if (name_q.size() == 0) begin
         name_q.push_back(text_char());
      end
   endtask

   task automatic random_phase();
      int r;
      int len;
      int n;
      int i;
      int k;
      int names;
      logic cut;
      r = $urandom_range(0, 19);
      if (r < 14) begin
         len = $urandom_range(0, 8);
      end else if (r < 18) begin
         len = $urandom_range(9, 32);
      end else if (r == 18) begin
         len = MAX_PATTERN;
      end else begin
         len = $urandom_range(33, 63);
      end
      n = (len > MAX_PATTERN) ? MAX_PATTERN : len;
      for (i = 0; i < MAX_PATTERN; i++) begin
         phase_pat[i] = (i < len) ? pattern_char() : CHAR_W'($urandom_range(0, 255));
      end
      write_csr(CSR_PATTERN_WORD_0, pack_word(0));
      write_csr(CSR_PATTERN_WORD_1, pack_word(1));
      write_csr(CSR_PATTERN_WORD_2, pack_word(2));
      write_csr(CSR_PATTERN_WORD_3, pack_word(3));
      write_csr(CSR_PATTERN_LENGTH, WORD_W'(len));
      if ($urandom_range(0, 1) == 1) begin
         write_csr(CSR_CASE_FOLD, WORD_W'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 1) == 1) begin
         write_csr(CSR_PATTERN_ENABLE, WORD_W'($urandom_range(0, 4) != 0));
      end
      settings_used++;
      calm  = ($urandom_range(0, 3) == 0);
      names = $urandom_range(2, 12);
      for (k = 0; k < names; k++) begin
         build_name(n, sb.fold_on);
         // leave the final name open now and then so the next pattern sees held state
         cut = (k == names - 1) && ($urandom_range(0, 3) == 0);
         for (i = 0; i < name_q.size(); i++) begin
            send_char(name_q[i], !cut && (i == name_q.size() - 1));
         end
      end
      settle();
   endtask

   // ready side: random stall before each transfer
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_match_here, rsp_last_res);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               sb.pending());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int base;
      sb = new();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // reset settings: empty pattern matches nothing
      send_char("x", 1'b1);
      send_char(8'hFF, 1'b1);
      settle();

      // folded literals around a star and a question mark, zero text byte
      set_regs(WORD_W'({8'h7A, CHAR_QMARK, CHAR_STAR, 8'h41}), '0, '0, '0, 4,
               1'b1, 1'b1);
      send_char("a", 1'b0);
      send_char("B", 1'b0);
      send_char(8'h00, 1'b0);
      send_char("Z", 1'b1);
      settle();

      // zero byte as a pattern literal, no folding
      set_regs(64'h0078, '1, '0, '1, 2, 1'b0, 1'b1);
      send_char("x", 1'b0);
      send_char(8'h00, 1'b1);
      send_char("X", 1'b1);
      settle();

      // disabled pattern matches everything
      write_csr(CSR_PATTERN_ENABLE, WORD_W'(1'b0));
      send_text("qr", 1'b1);
      settle();

      // oversized length clamps to a full pattern of stars
      set_regs({8{CHAR_STAR}}, {8{CHAR_STAR}}, {8{CHAR_STAR}}, {8{CHAR_STAR}}, 63,
               1'b0, 1'b1);
      send_char("Q", 1'b0);
      send_char(8'hFF, 1'b1);
      settle();

      // swap the pattern in the middle of a name
      set_regs(64'h6261, '0, '0, '0, 2, 1'b0, 1'b1);
      send_char("a", 1'b0);
      settle();
      write_csr(CSR_PATTERN_WORD_0, 64'h6258);
      send_char("b", 1'b1);
      settle();

      base = chars_sent;
      while (chars_sent - base < RANDOM_CHARS) begin
         random_phase();
      end

      calm = 1'b0;
      settle();
      repeat (8) @(negedge clock);
      $display("streamed %0d characters in %0d names across %0d pattern settings",
               chars_sent, names_sent, settings_used);
      $display("checked %0d verdicts, %0d names matched in full, %0d mismatches",
               sb.checked, sb.name_hits, sb.errors);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
